@@ rtl/core/byte_ring_queue_line_reader_macros.svh @@
// Assertion macros for the byte ring queue line reader.
// No dependencies; included by the modules that assert.
`ifndef BYTE_RING_QUEUE_LINE_READER_MACROS_SVH
`define BYTE_RING_QUEUE_LINE_READER_MACROS_SVH
`ifndef SYNTHESIS
`define BRQ_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("brq assertion failed");
`define BRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("brq assertion failed");
`else
`define BRQ_ASSERT(lbl, clk, rst_n, ante, cons)
`define BRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/brq_pkg.sv @@
// Shared types and constants for the byte ring queue line reader.
// No dependencies.
package brq_pkg;
	localparam int DEPTH  = 256;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int LIM_W  = 7;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	typedef logic [2:0]       action_t;
	typedef logic [7:0]       byte_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [LIM_W-1:0] lim_t;

	localparam action_t ACT_CLEAR = 3'd0;
	localparam action_t ACT_PUSH  = 3'd1;
	localparam action_t ACT_POP   = 3'd2;
	localparam action_t ACT_UNGET = 3'd3;
	localparam action_t ACT_READ  = 3'd4;

	localparam logic [APB_AW-1:0] ADDR_LINE_LIMIT = 2'd0;

	localparam lim_t  LIMIT_MIN   = 7'd3;
	localparam lim_t  LIMIT_MAX   = 7'd66;
	localparam lim_t  LIMIT_RESET = 7'd66;
	localparam lim_t  LIMIT_SLACK = 7'd2;
	localparam byte_t NEWLINE     = 8'h0A;

	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		byte_t wdata;
		logic  re;
		ptr_t  raddr;
	} store_req_t;
endpackage

@@ rtl/core/brq_if.sv @@
// Valid/ready channel interfaces for commands and results.
// Depends on brq_pkg.
interface brq_cmd_if import brq_pkg::*; ();
	logic    valid;
	logic    ready;
	action_t action;
	byte_t   data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

interface brq_rsp_if import brq_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  ok;
	byte_t out_byte;
	logic  last;
	logic  no_line;
	byte_t fill_count;
	byte_t free_count;

	modport source (output valid, ok, out_byte, last, no_line, fill_count, free_count,
		input ready);
	modport sink (input valid, ok, out_byte, last, no_line, fill_count, free_count,
		output ready);
endinterface

@@ rtl/core/brq_store.sv @@
// Byte store: single-port-write, registered-read memory with per-entry valid bits.
// Entries never written read as zero. Depends on brq_pkg.
module brq_store import brq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output byte_t      rdata
);
	byte_t            mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	byte_t            rdata_q;
	logic             rvalid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvalid_q <= valid_q[req.raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;
endmodule

@@ rtl/core/byte_ring_queue_line_reader.sv @@
// Byte ring queue with line read. Push, unget, clear: result registered on acceptance.
// Pop: one store read, then result. Read line: a scan pass of one stored byte per cycle
// up to the newline, then one line byte per cycle while the response is taken; both set
// by the store read port. One command is in flight at a time; the result register lets
// the next one in. Reset clears pointers, line limit (66) and store valid bits.
`include "byte_ring_queue_line_reader_macros.svh"
module byte_ring_queue_line_reader import brq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	brq_cmd_if.sink           cmd,
	brq_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q, state_n;
	ptr_t       wp_q, wp_n, rp_q, rp_n;
	ptr_t       scan_q, scan_n, end_q, end_n, emit_q, emit_n;
	lim_t       rem_q, rem_n, limit_q, lim, keep;
	logic       rd_s1, rd_s1_n, rd_last_s1, rd_last_n;
	ptr_t       rd_addr_s1, rd_addr_n;
	ptr_t       line_len;

	logic       out_valid_q, ok_q, last_q, noline_q;
	byte_t      byte_q, fill_q;
	logic       load_out, ld_ok, ld_last, ld_noline;
	byte_t      ld_byte, ld_fill;

	store_req_t sreq;
	byte_t      rd_data;
	logic       out_free, acc, full, empty;

	brq_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rdata  (rd_data)
	);

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LINE_LIMIT) ? {{(APB_DW-LIM_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			limit_q <= pwdata[LIM_W-1:0];
		end
	end

	assign lim  = (limit_q < LIMIT_MIN) ? LIMIT_MIN :
		(limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
	assign keep = lim - LIMIT_SLACK;

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign acc       = cmd.valid && cmd.ready;
	assign full      = (wp_q + 8'd1) == rp_q;
	assign empty     = wp_q == rp_q;
	assign line_len  = rd_addr_s1 + 8'd1 - rp_q;

	always_comb begin
		state_n   = state_q;
		wp_n      = wp_q;
		rp_n      = rp_q;
		scan_n    = scan_q;
		end_n     = end_q;
		emit_n    = emit_q;
		rem_n     = rem_q;
		rd_s1_n   = rd_s1;
		rd_addr_n = rd_addr_s1;
		rd_last_n = rd_last_s1;
		sreq      = '0;
		load_out  = 1'b0;
		ld_ok     = 1'b0;
		ld_byte   = '0;
		ld_last   = 1'b1;
		ld_noline = 1'b0;
		ld_fill   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					load_out = 1'b1;
					case (cmd.action)
						ACT_CLEAR: begin
							wp_n = '0;
							rp_n = '0;
						end
						ACT_PUSH: begin
							if (!full) begin
								sreq.we    = 1'b1;
								sreq.waddr = wp_q;
								sreq.wdata = cmd.data_byte;
								wp_n       = wp_q + 8'd1;
								ld_ok      = 1'b1;
							end
						end
						ACT_POP: begin
							if (!empty) begin
								load_out   = 1'b0;
								sreq.re    = 1'b1;
								sreq.raddr = rp_q;
								rp_n       = rp_q + 8'd1;
								state_n    = ST_POP;
							end
						end
						ACT_UNGET: begin
							if ((rp_q - 8'd1) != wp_q) begin
								rp_n = rp_q - 8'd1;
							end
						end
						ACT_READ: begin
							load_out = 1'b0;
							scan_n   = rp_q;
							rd_s1_n  = 1'b0;
							state_n  = ST_SCAN;
						end
						default: begin
						end
					endcase
					ld_fill = wp_n - rp_n;
				end
			end
			ST_POP: begin
				load_out = 1'b1;
				ld_ok    = 1'b1;
				ld_byte  = rd_data;
				ld_fill  = wp_q - rp_q;
				state_n  = ST_IDLE;
			end
			ST_SCAN: begin
				if (rd_s1 && rd_data == NEWLINE) begin
					end_n   = rd_addr_s1 + 8'd1;
					rem_n   = (line_len > {1'b0, keep}) ? keep : line_len[LIM_W-1:0];
					emit_n  = rp_q;
					rd_s1_n = 1'b0;
					state_n = ST_EMIT;
				end else if (!rd_s1 && scan_q == wp_q) begin
					if ((wp_q - rp_q) == 8'd1) begin
						rp_n = wp_q;
					end
					load_out  = 1'b1;
					ld_noline = 1'b1;
					ld_fill   = wp_q - rp_n;
					state_n   = ST_IDLE;
				end else if (scan_q != wp_q) begin
					sreq.re   = 1'b1;
					sreq.raddr = scan_q;
					scan_n    = scan_q + 8'd1;
					rd_s1_n   = 1'b1;
					rd_addr_n = scan_q;
				end else begin
					rd_s1_n = 1'b0;
				end
			end
			ST_EMIT: begin
				if (rd_s1 && out_free) begin
					load_out = 1'b1;
					ld_ok    = 1'b1;
					ld_byte  = rd_data;
					ld_last  = rd_last_s1;
					ld_fill  = wp_q - end_q;
					rd_s1_n  = 1'b0;
					if (rd_last_s1) begin
						rp_n    = end_q;
						state_n = ST_IDLE;
					end
				end
				if (rem_q != '0 && (!rd_s1 || out_free)) begin
					sreq.re    = 1'b1;
					sreq.raddr = emit_q;
					emit_n     = emit_q + 8'd1;
					rem_n      = rem_q - 7'd1;
					rd_s1_n    = 1'b1;
					rd_last_n  = rem_q == 7'd1;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_n;
			wp_q    <= wp_n;
			rp_q    <= rp_n;
			rd_s1   <= rd_s1_n;
		end
	end

	always_ff @(posedge clk) begin
		scan_q     <= scan_n;
		end_q      <= end_n;
		emit_q     <= emit_n;
		rem_q      <= rem_n;
		rd_addr_s1 <= rd_addr_n;
		rd_last_s1 <= rd_last_n;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ok_q     <= ld_ok;
			byte_q   <= ld_byte;
			last_q   <= ld_last;
			noline_q <= ld_noline;
			fill_q   <= ld_fill;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.ok         = ok_q;
	assign rsp.out_byte   = byte_q;
	assign rsp.last       = last_q;
	assign rsp.no_line    = noline_q;
	assign rsp.fill_count = fill_q;
	assign rsp.free_count = ~fill_q;

	`BRQ_ASSERT(a_load_free, clk, arst_n, load_out, out_free)
	`BRQ_ASSERT(a_emit_rem, clk, arst_n, state_q == ST_EMIT && rem_q == '0, rd_s1)
	`BRQ_ASSERT_NEXT(a_hold_data, clk, arst_n, state_q == ST_EMIT && rd_s1 && !out_free, $stable(rd_data))
	`BRQ_ASSERT_NEXT(a_push_adv, clk, arst_n, acc && cmd.action == ACT_PUSH && !full, wp_q == $past(wp_q) + 8'd1)
endmodule

@@ tb/sv/tb_byte_ring_queue_line_reader.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for byte_ring_queue_line_reader: drives actions and the
// line_limit register, predicts every response with a scoreboard class.
// Depends on brq_pkg, brq_if and the block itself.
import brq_pkg::*;

typedef struct packed {
	logic  ok;
	byte_t out_byte;
	logic  last;
	logic  no_line;
	byte_t fill_count;
	byte_t free_count;
} line_rsp_t;

class line_reader_scoreboard;
	byte_t     cells [DEPTH];
	ptr_t      wr_ptr;
	ptr_t      rd_ptr;
	lim_t      line_limit;
	line_rsp_t predicted_rsp [$];
	int        errors;

	function new();
		foreach (cells[i])
			cells[i] = '0;
		wr_ptr     = '0;
		rd_ptr     = '0;
		line_limit = LIMIT_RESET;
		errors     = 0;
	endfunction

	task report(string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		errors++;
	endtask

	function ptr_t ring_next(ptr_t p);
		return (int'(p) == DEPTH - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
	endfunction

	function ptr_t ring_prev(ptr_t p);
		return (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
	endfunction

	function void add_rsp(logic ok, byte_t b, logic no_line);
		int        held;
		int        room;
		line_rsp_t r;
		held = (wr_ptr >= rd_ptr) ? int'(wr_ptr) - int'(rd_ptr)
			: int'(wr_ptr) + DEPTH - int'(rd_ptr);
		room = DEPTH - 1 - held;
		r.ok         = ok;
		r.out_byte   = b;
		r.last       = 1'b0;
		r.no_line    = no_line;
		r.fill_count = (held > 255) ? 8'hFF : byte_t'(held);
		r.free_count = (room > 255) ? 8'hFF : byte_t'(room);
		predicted_rsp.push_back(r);
	endfunction

	// Applies one accepted action; responses carry counts as they are after it.
	function void predict_action(action_t act, byte_t data);
		ptr_t  p;
		lim_t  lim;
		int    keep;
		bit    found;
		byte_t b;
		byte_t line_bytes [$];
		case (act)
			ACT_CLEAR: begin
				wr_ptr = '0;
				rd_ptr = '0;
				add_rsp(1'b0, 8'h00, 1'b0);
			end
			ACT_PUSH: begin
				if (ring_next(wr_ptr) != rd_ptr) begin
					cells[wr_ptr] = data;
					wr_ptr = ring_next(wr_ptr);
					add_rsp(1'b1, 8'h00, 1'b0);
				end else begin
					add_rsp(1'b0, 8'h00, 1'b0);
				end
			end
			ACT_POP: begin
				if (wr_ptr != rd_ptr) begin
					b = cells[rd_ptr];
					rd_ptr = ring_next(rd_ptr);
					add_rsp(1'b1, b, 1'b0);
				end else begin
					add_rsp(1'b0, 8'h00, 1'b0);
				end
			end
			ACT_UNGET: begin
				if (ring_prev(rd_ptr) != wr_ptr)
					rd_ptr = ring_prev(rd_ptr);
				add_rsp(1'b0, 8'h00, 1'b0);
			end
			ACT_READ: begin
				lim = line_limit;
				if (lim < LIMIT_MIN)
					lim = LIMIT_MIN;
				if (lim > LIMIT_MAX)
					lim = LIMIT_MAX;
				keep  = int'(lim) - int'(LIMIT_SLACK);
				found = 1'b0;
				p     = rd_ptr;
				while (p != wr_ptr) begin
					b = cells[p];
					if (line_bytes.size() < keep)
						line_bytes.push_back(b);
					p = ring_next(p);
					if (b == NEWLINE) begin
						found = 1'b1;
						break;
					end
				end
				if (found) begin
					rd_ptr = p;
					foreach (line_bytes[i])
						add_rsp(1'b1, line_bytes[i], 1'b0);
				end else begin
					// a lone byte without newline is thrown away
					if (ring_next(rd_ptr) == wr_ptr)
						rd_ptr = wr_ptr;
					add_rsp(1'b0, 8'h00, 1'b1);
				end
			end
			default: add_rsp(1'b0, 8'h00, 1'b0);
		endcase
		predicted_rsp[predicted_rsp.size() - 1].last = 1'b1;
	endfunction

	task check_result(line_rsp_t got);
		line_rsp_t exp;
		string     diffs;
		if (predicted_rsp.size() == 0) begin
			report($sformatf("unexpected response byte=%02h fill=%0d", got.out_byte,
				got.fill_count));
		end else begin
			exp   = predicted_rsp.pop_front();
			diffs = "";
			if (got.ok !== exp.ok)
				diffs = {diffs, $sformatf(" ok=%0b/%0b", got.ok, exp.ok)};
			if (got.out_byte !== exp.out_byte)
				diffs = {diffs, $sformatf(" out_byte=%02h/%02h", got.out_byte, exp.out_byte)};
			if (got.last !== exp.last)
				diffs = {diffs, $sformatf(" last=%0b/%0b", got.last, exp.last)};
			if (got.no_line !== exp.no_line)
				diffs = {diffs, $sformatf(" no_line=%0b/%0b", got.no_line, exp.no_line)};
			if (got.fill_count !== exp.fill_count)
				diffs = {diffs, $sformatf(" fill=%0d/%0d", got.fill_count, exp.fill_count)};
			if (got.free_count !== exp.free_count)
				diffs = {diffs, $sformatf(" free=%0d/%0d", got.free_count, exp.free_count)};
			if (diffs != "")
				report({"response (got/exp):", diffs});
		end
	endtask
endclass

module tb_byte_ring_queue_line_reader;
	localparam int      IDLE_LIMIT = 5000;
	localparam int      GAP_PCT    = 35;
	localparam action_t ACT_TOP    = '1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	brq_cmd_if cmd_ch ();
	brq_rsp_if rsp_ch ();

	line_reader_scoreboard sb;
	bit gaps_on;
	int idle_cycles;

	byte_ring_queue_line_reader i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (cmd_ch.valid && cmd_ch.ready) begin
				sb.predict_action(cmd_ch.action, cmd_ch.data_byte);
				idle_cycles = 0;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_result('{rsp_ch.ok, rsp_ch.out_byte, rsp_ch.last, rsp_ch.no_line,
					rsp_ch.fill_count, rsp_ch.free_count});
				idle_cycles = 0;
			end
			if (psel && penable && pready)
				idle_cycles = 0;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic byte_t plain_byte();
		byte_t b;
		b = byte_t'($urandom);
		return (b == NEWLINE) ? (b ^ 8'h01) : b;
	endfunction

	task automatic send_cmd(action_t act, byte_t data);
		if (gaps_on) begin
			while ($urandom_range(99) < GAP_PCT) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.action    <= act;
		cmd_ch.data_byte <= data;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.predicted_rsp.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write, then read back; upper data bits are junk the register drops.
	task automatic write_line_limit(lim_t lim);
		logic [APB_DW-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_LINE_LIMIT;
		pwdata  <= ($urandom & ~APB_DW'(8'h7F)) | APB_DW'(lim);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.line_limit = lim;
		@(posedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DW'(lim))
			sb.report($sformatf("line_limit readback %0h, expected %0h", rd, lim));
		@(posedge clk);
	endtask

	task automatic send_line(int len);
		repeat (len) send_cmd(ACT_PUSH, plain_byte());
		send_cmd(ACT_PUSH, NEWLINE);
	endtask

	task automatic fill_to_full();
		send_cmd(ACT_CLEAR, byte_t'($urandom));
		for (int i = 0; i < DEPTH; i++)
			send_cmd(ACT_PUSH, (i == 100 || i == 180) ? NEWLINE : plain_byte());
		send_cmd(ACT_UNGET, byte_t'($urandom));
		send_cmd(ACT_PUSH, byte_t'($urandom));
		send_cmd(ACT_READ, byte_t'($urandom));
		send_cmd(ACT_UNGET, byte_t'($urandom));
		send_cmd(ACT_READ, byte_t'($urandom));
		send_cmd(ACT_POP, byte_t'($urandom));
	endtask

	task automatic random_traffic(int n_items);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 45) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(6);
				send_line(len);
				sent += len + 1;
				if ($urandom_range(99) < 70) begin
					send_cmd(ACT_READ, byte_t'($urandom));
					sent++;
				end
			end else begin
				if (r < 60)
					send_cmd(ACT_POP, byte_t'($urandom));
				else if (r < 68)
					send_cmd(ACT_UNGET, byte_t'($urandom));
				else if (r < 78)
					send_cmd(ACT_READ, byte_t'($urandom));
				else if (r < 82)
					send_cmd(ACT_CLEAR, byte_t'($urandom));
				else if (r < 86)
					send_cmd(action_t'($urandom_range(int'(ACT_READ) + 1, int'(ACT_TOP))),
						byte_t'($urandom));
				else
					send_cmd(ACT_PUSH, byte_t'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		lim_t limits [$];
		sb = new();
		clk              = 1'b0;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.action    = ACT_CLEAR;
		cmd_ch.data_byte = '0;
		rsp_ch.ready     = 1'b0;
		gaps_on          = 1'b1;
		idle_cycles      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, unget into reset cells, lines, lone byte, junk actions
		send_cmd(ACT_READ, 8'h00);
		send_cmd(ACT_POP, 8'hFF);
		send_cmd(ACT_UNGET, 8'h00);
		send_cmd(ACT_POP, 8'h00);
		send_cmd(ACT_PUSH, 8'h00);
		send_cmd(ACT_PUSH, 8'hFF);
		send_cmd(ACT_PUSH, 8'h41);
		send_cmd(ACT_PUSH, NEWLINE);
		send_cmd(ACT_READ, 8'hFF);
		send_cmd(ACT_PUSH, 8'h55);
		send_cmd(ACT_READ, 8'h00);
		send_cmd(ACT_PUSH, 8'h12);
		send_cmd(ACT_PUSH, 8'h34);
		send_cmd(ACT_READ, 8'h00);
		send_cmd(ACT_POP, 8'h00);
		send_cmd(ACT_UNGET, 8'h00);
		send_cmd(ACT_POP, 8'h00);
		send_cmd(ACT_POP, 8'h00);
		send_cmd(ACT_CLEAR, 8'hFF);
		send_cmd(ACT_UNGET, 8'hFF);
		send_cmd(action_t'(int'(ACT_READ) + 1), 8'hAA);
		send_cmd(action_t'(int'(ACT_READ) + 2), 8'h55);
		send_cmd(ACT_TOP, 8'hFF);
		send_cmd(ACT_PUSH, NEWLINE);
		send_cmd(ACT_READ, 8'h00);
		wait_drained();

		// full queue and truncated line with no gaps on either side
		gaps_on = 1'b0;
		write_line_limit(LIMIT_MAX);
		fill_to_full();
		random_traffic(25);
		wait_drained();
		gaps_on = 1'b1;

		limits = '{LIMIT_MIN, 7'd0, 7'd127, 7'd20, 7'd2, 7'd67,
			lim_t'($urandom_range(int'(LIMIT_MIN), int'(LIMIT_MAX)))};
		foreach (limits[i]) begin
			write_line_limit(limits[i]);
			random_traffic(22);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (sb.predicted_rsp.size() != 0)
			sb.report($sformatf("%0d responses never arrived", sb.predicted_rsp.size()));
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
